// File: rtl/core/bsls_pkg.sv
package bsls_pkg;

  // default store depth and element width
  localparam int unsigned MaxItemsDef = 16;
  localparam int unsigned DataW       = 32;

  // one request: an element and the flag that closes the set
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } req_t;

  // one result: the next sorted element and the end-of-run flag
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_res;
  } res_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_FIRST,
    ST_CMP,
    ST_END,
    ST_EMIT
  } state_e;

  // source of the store write data
  typedef enum logic [1:0] {
    WR_INPUT,
    WR_MIN,
    WR_CARRY
  } wsel_e;

  // update of the carried element
  typedef enum logic [1:0] {
    CARRY_HOLD,
    CARRY_LOAD,
    CARRY_MAX
  } carry_e;

  // datapath control from the sequencer
  typedef struct packed {
    logic   we;
    wsel_e  wsel;
    carry_e cop;
  } ctl_t;

endpackage

// File: rtl/core/bsls_dp.sv
module bsls_dp #(
  parameter int unsigned MAX_ITEMS = bsls_pkg::MaxItemsDef,
  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                          clk_i,
  input  bsls_pkg::ctl_t                ctl_i,
  input  logic [IdxW-1:0]               waddr_i,
  input  logic [IdxW-1:0]               raddr_i,
  input  logic [bsls_pkg::DataW-1:0]    in_value_i,
  output logic                          gt_o,
  output logic [bsls_pkg::DataW-1:0]    rdata_o
);
  import bsls_pkg::*;

  logic [DataW-1:0] mem_q [MAX_ITEMS];
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] carry_q, carry_d;
  logic [DataW-1:0] wdata;
  logic             gt;

  // shared signed compare: carried element against the element just read
  assign gt = $signed(carry_q) > $signed(rdata_q);

  // write data select
  always_comb begin
    case (ctl_i.wsel)
      WR_INPUT: wdata = in_value_i;
      WR_MIN:   wdata = gt ? rdata_q : carry_q;
      WR_CARRY: wdata = carry_q;
      default:  wdata = carry_q;
    endcase
  end

  // carried element keeps the larger of each compared pair
  always_comb begin
    case (ctl_i.cop)
      CARRY_HOLD: carry_d = carry_q;
      CARRY_LOAD: carry_d = rdata_q;
      CARRY_MAX:  carry_d = gt ? carry_q : rdata_q;
      default:    carry_d = carry_q;
    endcase
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // carry register
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign gt_o    = gt;
  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bsls_seq.sv
module bsls_seq #(
  parameter int unsigned MAX_ITEMS = bsls_pkg::MaxItemsDef,
  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            last_i,
  input  logic            gt_i,
  output bsls_pkg::ctl_t  ctl_o,
  output logic [IdxW-1:0] waddr_o,
  output logic [IdxW-1:0] raddr_o,
  output logic            busy_o,
  output logic            res_valid_o,
  output logic            res_last_o
);
  import bsls_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [IdxW-1:0] bound_q, bound_d;
  logic [IdxW-1:0] lsp_q, lsp_d;
  logic            swapped_q, swapped_d;
  logic            valid_q, valid_d;
  logic            last_q, last_d;

  logic            accept;
  logic            full;
  logic [CntW-1:0] new_count;
  logic [IdxW-1:0] j_inc;
  logic            cmp_more;
  logic            emit_last;

  // request handshake and loop conditions
  assign accept    = start_i && !busy_o;
  assign full      = count_q == CntW'(MAX_ITEMS);
  assign new_count = full ? count_q : count_q + CntW'(1);
  assign j_inc     = j_q + IdxW'(1);
  assign cmp_more  = j_inc < bound_q;
  assign emit_last = (CntW'(j_q) + CntW'(1)) == count_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && last_i) begin
          state_d = (new_count > CntW'(1)) ? ST_START : ST_EMIT;
        end
      end
      ST_START: state_d = ST_FIRST;
      ST_FIRST: state_d = ST_CMP;
      ST_CMP: begin
        if (!cmp_more) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        state_d = (swapped_q && (lsp_q != '0)) ? ST_START : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs, counters and datapath control
  always_comb begin
    ctl_o     = '{we: 1'b0, wsel: WR_INPUT, cop: CARRY_HOLD};
    waddr_o   = j_q;
    raddr_o   = j_q;
    count_d   = count_q;
    j_d       = j_q;
    bound_d   = bound_q;
    lsp_d     = lsp_q;
    swapped_d = swapped_q;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    case (state_q)
      ST_LOAD: begin
        waddr_o  = count_q[IdxW-1:0];
        ctl_o.we = accept && !full;
        if (accept) begin
          count_d = new_count;
          if (last_i) begin
            bound_d = IdxW'(new_count - CntW'(1));
            j_d     = '0;
          end
        end
      end
      ST_START: begin
        raddr_o   = '0;
        j_d       = '0;
        lsp_d     = '0;
        swapped_d = 1'b0;
      end
      ST_FIRST: begin
        raddr_o   = j_inc;
        ctl_o.cop = CARRY_LOAD;
      end
      ST_CMP: begin
        // write the smaller element back, carry the larger one on
        ctl_o.we   = 1'b1;
        ctl_o.wsel = WR_MIN;
        ctl_o.cop  = CARRY_MAX;
        waddr_o    = j_q;
        raddr_o    = j_q + IdxW'(2);
        j_d        = j_inc;
        if (gt_i) begin
          swapped_d = 1'b1;
          lsp_d     = j_q;
        end
      end
      ST_END: begin
        // carried element lands at the end of the pass
        ctl_o.we   = 1'b1;
        ctl_o.wsel = WR_CARRY;
        waddr_o    = bound_q;
        bound_d    = lsp_q;
        j_d        = '0;
      end
      ST_EMIT: begin
        raddr_o = j_q;
        j_d     = j_inc;
        valid_d = 1'b1;
        last_d  = emit_last;
        if (emit_last) begin
          count_d = '0;
          j_d     = '0;
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      j_q       <= '0;
      bound_q   <= '0;
      lsp_q     <= '0;
      swapped_q <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      j_q       <= j_d;
      bound_q   <= bound_d;
      lsp_q     <= lsp_d;
      swapped_q <= swapped_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  assign busy_o      = (state_q != ST_LOAD) || valid_q;
  assign res_valid_o = valid_q;
  assign res_last_o  = last_q;

endmodule

// File: rtl/core/bubble_sort_last_swap_unit.sv
// Collects up to MAX_ITEMS signed 32-bit values, one per request while busy_o
// is low; extra values past MAX_ITEMS are dropped. The request with last set
// closes the set and starts an in-place bubble sort over a single-port-write
// element store with one shared signed comparator, and the next pass ends at
// the last swap. The sorted values then leave back to back in ascending order,
// each marked by res_valid_o for a single cycle, the final one with last_res
// set. The receiver cannot stall: res_o must be taken whenever res_valid_o is
// high. busy_o stays high from the closing request until the final result has
// been shown.
module bubble_sort_last_swap_unit #(
  parameter int unsigned MAX_ITEMS = bsls_pkg::MaxItemsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bsls_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output bsls_pkg::res_t res_o
);
  import bsls_pkg::*;

  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  ctl_t             ctl;
  logic [IdxW-1:0]  waddr;
  logic [IdxW-1:0]  raddr;
  logic             gt;
  logic [DataW-1:0] rdata;
  logic             res_last;

  // sequencer
  bsls_seq #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .last_i     (req_i.last),
    .gt_i       (gt),
    .ctl_o      (ctl),
    .waddr_o    (waddr),
    .raddr_o    (raddr),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_last_o (res_last)
  );

  // store, carry register and comparator
  bsls_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .waddr_i   (waddr),
    .raddr_i   (raddr),
    .in_value_i(req_i.value),
    .gt_o      (gt),
    .rdata_o   (rdata)
  );

  // result assembly
  assign res_o.sorted_value = rdata;
  assign res_o.last_res     = res_last;

endmodule

// File: rtl/core/bsls_chk.sv
module bsls_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input bsls_pkg::req_t req_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input bsls_pkg::res_t res_o
);
  import bsls_pkg::*;

  // results only while the unit reports busy
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result shown while not busy");

  // a closing request always starts a run
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.last) |=> busy_o)
    else $error("closing request did not start a run");

  // results of a run are back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_res) |=> res_valid_o)
    else $error("gap inside a result run");

  // nothing follows the final result of a run
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_res) |=> !res_valid_o)
    else $error("result after the final one");

  // results come out in ascending order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_res) |=>
      ($signed(res_o.sorted_value) >= $signed($past(res_o.sorted_value))))
    else $error("results out of order");

endmodule

bind bubble_sort_last_swap_unit bsls_chk u_bsls_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .req_i      (req_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
